### rtl/bccc_pkg.sv
package bccc_pkg;

    localparam int DEF_CHUNK_COUNT  = 16;
    localparam int DEF_CHUNK_BLOCKS = 64;

    localparam logic [31:0] DEVICE_BLOCKS_RESET = 32'hFFFF_FFFF;
    localparam logic        REG_DEVICE_BLOCKS   = 1'b0;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [2:0] KIND_LOOKUP  = 3'd0;
    localparam logic [2:0] KIND_RUN     = 3'd1;
    localparam logic [2:0] KIND_MARKED  = 3'd2;
    localparam logic [2:0] KIND_FLUSHED = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

endpackage

### rtl/bccc_dirty_ram.sv
module bccc_dirty_ram #(
    parameter int DEPTH = bccc_pkg::DEF_CHUNK_COUNT,
    parameter int WIDTH = bccc_pkg::DEF_CHUNK_BLOCKS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);
    import bccc_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/block_chunk_cache_controller_core.sv
// Tag and state controller of a fully associative write-back cache of aligned block chunks.
// Tags, use stamps and valid counts sit in registers; the per-block dirty bits sit in a
// synchronous memory with one row per chunk, read and written back whole. A request is
// accepted only while the controller is idle. S_DIV takes the quotient by a reciprocal
// multiply and S_ALIGN corrects it to align the address, then S_FIND compares the tags. A
// lookup hit, a clean flush, a bad select or a mark miss ends in S_FIND; a mark dirty reads
// the dirty row there and writes it back in S_MARK. A miss takes the victim in S_VICT and
// fills it in S_FILL; with every chunk present and more than one chunk, S_LRU first walks
// for the least recently used one. A dirty victim or a dirty flush waits in S_RD for the
// dirty row and scans its valid blocks in S_SCAN, writing the row back at the end; a dirty
// flush then gives its flush-done result in S_FLUSHED. Each result waits in the output
// register while the result channel stalls, and the controller holds until that register
// is free. There is no clearing pass: a row is written whole when its chunk is filled.
module block_chunk_cache_controller_core #(
    parameter int CHUNK_COUNT  = bccc_pkg::DEF_CHUNK_COUNT,
    parameter int CHUNK_BLOCKS = bccc_pkg::DEF_CHUNK_BLOCKS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_block_addr,
    input  logic [6:0]  s_block_count,
    input  logic [3:0]  s_chunk_select,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic        m_hit,
    output logic [3:0]  m_chunk_index,
    output logic [31:0] m_run_start,
    output logic [6:0]  m_run_length,
    output logic        m_last
);
    import bccc_pkg::*;

    localparam int IDX_W = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int OFF_W = $clog2(CHUNK_BLOCKS);
    localparam int CNT_W = $clog2(CHUNK_BLOCKS + 1);
    localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / CHUNK_BLOCKS;
    localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
    localparam logic [31:0] CB_32 = 32'(CHUNK_BLOCKS);
    localparam logic [CNT_W-1:0] CB_CNT = CNT_W'(CHUNK_BLOCKS);
    localparam logic [8:0] CB_9 = 9'(CHUNK_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHUNK_COUNT - 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_DIV     = 11'b000_0000_0010,
        S_ALIGN   = 11'b000_0000_0100,
        S_FIND    = 11'b000_0000_1000,
        S_LRU     = 11'b000_0001_0000,
        S_VICT    = 11'b000_0010_0000,
        S_RD      = 11'b000_0100_0000,
        S_SCAN    = 11'b000_1000_0000,
        S_MARK    = 11'b001_0000_0000,
        S_FILL    = 11'b010_0000_0000,
        S_FLUSHED = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic             en;
        logic [2:0]       kind;
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [31:0]      start;
        logic [CNT_W-1:0] len;
        logic             last;
    } emit_t;

    state_t state_reg, state_next;

    logic [1:0]  op_reg;
    logic [31:0] addr_reg;
    logic [6:0]  count_reg;
    logic [3:0]  sel_reg;
    logic [31:0] quot_reg;
    logic [31:0] base_reg;
    logic [OFF_W-1:0] off_reg;

    logic [IDX_W-1:0] ci_reg, ci_next;
    logic [IDX_W-1:0] lru_idx_reg, lru_idx_next;
    logic [IDX_W-1:0] lru_best_reg, lru_best_next;
    logic [31:0]      lru_val_reg, lru_val_next;
    logic [CNT_W-1:0] scan_k_reg, scan_k_next;
    logic             in_run_reg, in_run_next;
    logic [OFF_W-1:0] run_off_reg, run_off_next;
    logic [CNT_W-1:0] run_len_reg, run_len_next;

    logic [31:0]            use_cnt_reg;
    logic [31:0]            device_reg;
    logic [CHUNK_COUNT-1:0] present_reg;
    logic [CHUNK_COUNT-1:0] dirty_reg;
    logic [CNT_W-1:0]       valid_reg [CHUNK_COUNT];
    logic [31:0]            last_use_reg [CHUNK_COUNT];
    logic [31:0]            cbase_reg [CHUNK_COUNT];

    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    logic        m_hit_reg;
    logic [3:0]  m_chunk_index_reg;
    logic [31:0] m_run_start_reg;
    logic [6:0]  m_run_length_reg;
    logic        m_last_reg;

    emit_t em;
    logic out_free;
    logic stamp_en;
    logic [IDX_W-1:0] stamp_idx;
    logic fill_en;
    logic wb_done;
    logic set_dirty_en;
    logic rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic wr_en;
    logic [CHUNK_BLOCKS-1:0] wr_data;
    logic [CHUNK_BLOCKS-1:0] rd_data;

    logic hit_any, free_any;
    logic [IDX_W-1:0] hit_idx, free_idx;
    logic [IDX_W-1:0] sel_idx;
    logic sel_bad;

    logic [63:0] prod;
    logic [31:0] qcb, rem_raw, rem_fix;
    logic [CNT_W-1:0] off_c, valid_ci;
    logic [31:0] fill_diff;
    logic [CNT_W-1:0] fill_cnt;
    logic [8:0] end_sum, end_c;
    logic mark_ok;
    logic [CNT_W-1:0] marked;
    logic [CHUNK_BLOCKS-1:0] mark_mask;
    logic scan_bit;
    logic [31:0] ci_ext;
    logic cfg_wr;

    function automatic logic [CNT_W-1:0] avail_f(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] o);
        avail_f = (o < v) ? CNT_W'(v - o) : '0;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_DEVICE_BLOCKS);
    assign prdata   = (paddr[2] == REG_DEVICE_BLOCKS) ? device_reg : 32'd0;

    assign prod    = {32'd0, addr_reg} * {32'd0, RECIP};
    assign qcb     = quot_reg * CB_32;
    assign rem_raw = addr_reg - qcb;
    assign rem_fix = (rem_raw >= CB_32) ? rem_raw - CB_32 : rem_raw;

    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = CHUNK_COUNT - 1; i >= 0; i--) begin
            if (present_reg[i] && cbase_reg[i] == base_reg) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!present_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign sel_bad  = (32'(sel_reg) >= 32'(CHUNK_COUNT));
    assign sel_idx  = IDX_W'(sel_reg);
    assign off_c    = CNT_W'(off_reg);
    assign valid_ci = valid_reg[ci_reg];

    assign fill_diff = device_reg - base_reg;
    assign fill_cnt  = (fill_diff > CB_32) ? CB_CNT : CNT_W'(fill_diff);

    assign end_sum = 9'(off_reg) + 9'(count_reg);
    assign end_c   = (end_sum > CB_9) ? CB_9 : end_sum;
    assign mark_ok = (off_c < valid_ci);
    assign marked  = mark_ok ? CNT_W'(end_c - 9'(off_reg)) : '0;

    always_comb begin
        for (int j = 0; j < CHUNK_BLOCKS; j++) begin
            mark_mask[j] = mark_ok && (9'(j) >= 9'(off_reg)) && (9'(j) < end_c);
        end
    end

    assign scan_bit = (scan_k_reg < valid_ci) && rd_data[scan_k_reg[OFF_W-1:0]];

    always_comb begin
        state_next    = state_reg;
        ci_next       = ci_reg;
        lru_idx_next  = lru_idx_reg;
        lru_best_next = lru_best_reg;
        lru_val_next  = lru_val_reg;
        scan_k_next   = scan_k_reg;
        in_run_next   = in_run_reg;
        run_off_next  = run_off_reg;
        run_len_next  = run_len_reg;
        em            = '0;
        em.last       = 1'b1;
        stamp_en      = 1'b0;
        stamp_idx     = ci_reg;
        fill_en       = 1'b0;
        wb_done       = 1'b0;
        set_dirty_en  = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = ci_reg;
        wr_en         = 1'b0;
        wr_data       = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                state_next = S_ALIGN;
            end
            S_ALIGN: begin
                state_next = S_FIND;
            end
            S_FIND: begin
                if (out_free) begin
                    case (op_reg)
                        OP_LOOKUP: begin
                            if (hit_any) begin
                                em.en      = 1'b1;
                                em.kind    = KIND_LOOKUP;
                                em.hit     = 1'b1;
                                em.idx     = hit_idx;
                                em.start   = cbase_reg[hit_idx];
                                em.len     = avail_f(valid_reg[hit_idx], off_c);
                                stamp_en   = 1'b1;
                                stamp_idx  = hit_idx;
                                state_next = S_IDLE;
                            end else if (free_any) begin
                                ci_next    = free_idx;
                                state_next = S_VICT;
                            end else if (CHUNK_COUNT == 1) begin
                                ci_next    = '0;
                                state_next = S_VICT;
                            end else begin
                                lru_idx_next  = IDX_W'(1);
                                lru_best_next = '0;
                                lru_val_next  = last_use_reg[0];
                                state_next    = S_LRU;
                            end
                        end
                        OP_MARK: begin
                            if (hit_any) begin
                                ci_next    = hit_idx;
                                rd_en      = 1'b1;
                                rd_addr    = hit_idx;
                                state_next = S_MARK;
                            end else begin
                                em.en      = 1'b1;
                                em.kind    = KIND_ERROR;
                                state_next = S_IDLE;
                            end
                        end
                        OP_FLUSH: begin
                            if (sel_bad) begin
                                em.en      = 1'b1;
                                em.kind    = KIND_ERROR;
                                state_next = S_IDLE;
                            end else if (dirty_reg[sel_idx]) begin
                                ci_next    = sel_idx;
                                rd_en      = 1'b1;
                                rd_addr    = sel_idx;
                                state_next = S_RD;
                            end else begin
                                em.en      = 1'b1;
                                em.kind    = KIND_FLUSHED;
                                em.idx     = sel_idx;
                                em.start   = cbase_reg[sel_idx];
                                state_next = S_IDLE;
                            end
                        end
                        default: begin
                            em.en      = 1'b1;
                            em.kind    = KIND_ERROR;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LRU: begin
                if (last_use_reg[lru_idx_reg] < lru_val_reg) begin
                    lru_best_next = lru_idx_reg;
                    lru_val_next  = last_use_reg[lru_idx_reg];
                end
                if (lru_idx_reg == LAST_IDX) begin
                    ci_next    = lru_best_next;
                    state_next = S_VICT;
                end else begin
                    lru_idx_next = lru_idx_reg + IDX_W'(1);
                end
            end
            S_VICT: begin
                stamp_en = 1'b1;
                if (dirty_reg[ci_reg]) begin
                    rd_en      = 1'b1;
                    state_next = S_RD;
                end else begin
                    state_next = S_FILL;
                end
            end
            S_RD: begin
                scan_k_next  = '0;
                in_run_next  = 1'b0;
                run_len_next = '0;
                state_next   = S_SCAN;
            end
            S_SCAN: begin
                if (out_free) begin
                    if (scan_k_reg == valid_ci) begin
                        em.en      = in_run_reg;
                        wr_en      = 1'b1;
                        wr_data    = '0;
                        wb_done    = 1'b1;
                        state_next = (op_reg == OP_FLUSH) ? S_FLUSHED : S_FILL;
                    end else if (scan_bit) begin
                        if (!in_run_reg) begin
                            run_off_next = scan_k_reg[OFF_W-1:0];
                            run_len_next = CNT_W'(1);
                        end else begin
                            run_len_next = run_len_reg + CNT_W'(1);
                        end
                        in_run_next = 1'b1;
                        scan_k_next = scan_k_reg + CNT_W'(1);
                    end else begin
                        em.en       = in_run_reg;
                        in_run_next = 1'b0;
                        scan_k_next = scan_k_reg + CNT_W'(1);
                    end
                    em.kind  = KIND_RUN;
                    em.idx   = ci_reg;
                    em.start = cbase_reg[ci_reg] + 32'(run_off_reg);
                    em.len   = run_len_reg;
                    em.last  = 1'b0;
                end
            end
            S_MARK: begin
                if (out_free) begin
                    wr_en        = 1'b1;
                    wr_data      = rd_data | mark_mask;
                    stamp_en     = 1'b1;
                    set_dirty_en = (marked != '0);
                    em.en        = 1'b1;
                    em.kind      = KIND_MARKED;
                    em.idx       = ci_reg;
                    em.start     = addr_reg;
                    em.len       = marked;
                    state_next   = S_IDLE;
                end
            end
            S_FILL: begin
                if (out_free) begin
                    em.en  = 1'b1;
                    em.idx = ci_reg;
                    if (base_reg >= device_reg) begin
                        em.kind = KIND_ERROR;
                    end else begin
                        fill_en  = 1'b1;
                        wr_en    = 1'b1;
                        wr_data  = '0;
                        em.kind  = KIND_LOOKUP;
                        em.start = base_reg;
                        em.len   = avail_f(fill_cnt, off_c);
                    end
                    state_next = S_IDLE;
                end
            end
            S_FLUSHED: begin
                if (out_free) begin
                    em.en      = 1'b1;
                    em.kind    = KIND_FLUSHED;
                    em.idx     = ci_reg;
                    em.start   = cbase_reg[ci_reg];
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    bccc_dirty_ram #(
        .DEPTH (CHUNK_COUNT),
        .WIDTH (CHUNK_BLOCKS),
        .ADDR_W(IDX_W)
    ) u_dirty_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(ci_reg),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            use_cnt_reg  <= '0;
            device_reg   <= DEVICE_BLOCKS_RESET;
            present_reg  <= '0;
            dirty_reg    <= '0;
            valid_reg    <= '{default: '0};
            last_use_reg <= '{default: '0};
            cbase_reg    <= '{default: '0};
        end else begin
            state_reg <= state_next;
            if (em.en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                device_reg <= pwdata;
            end
            if (stamp_en) begin
                last_use_reg[stamp_idx] <= use_cnt_reg;
                use_cnt_reg             <= use_cnt_reg + 32'd1;
            end
            if (wb_done) begin
                dirty_reg[ci_reg] <= 1'b0;
            end
            if (set_dirty_en) begin
                dirty_reg[ci_reg] <= 1'b1;
            end
            if (fill_en) begin
                cbase_reg[ci_reg]   <= base_reg;
                valid_reg[ci_reg]   <= fill_cnt;
                present_reg[ci_reg] <= 1'b1;
                dirty_reg[ci_reg]   <= 1'b0;
            end
        end
    end

    assign ci_ext = 32'(em.idx);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_operation;
            addr_reg  <= s_block_addr;
            count_reg <= s_block_count;
            sel_reg   <= s_chunk_select;
        end
        if (state_reg == S_DIV) begin
            quot_reg <= prod[63:32];
        end
        if (state_reg == S_ALIGN) begin
            base_reg <= addr_reg - rem_fix;
            off_reg  <= rem_fix[OFF_W-1:0];
        end
        ci_reg       <= ci_next;
        lru_idx_reg  <= lru_idx_next;
        lru_best_reg <= lru_best_next;
        lru_val_reg  <= lru_val_next;
        scan_k_reg   <= scan_k_next;
        in_run_reg   <= in_run_next;
        run_off_reg  <= run_off_next;
        run_len_reg  <= run_len_next;
        if (em.en) begin
            m_kind_reg        <= em.kind;
            m_hit_reg         <= em.hit;
            m_chunk_index_reg <= ci_ext[3:0];
            m_run_start_reg   <= em.start;
            m_run_length_reg  <= 7'(em.len);
            m_last_reg        <= em.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_hit         = m_hit_reg;
    assign m_chunk_index = m_chunk_index_reg;
    assign m_run_start   = m_run_start_reg;
    assign m_run_length  = m_run_length_reg;
    assign m_last        = m_last_reg;

    a_dirty_needs_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (dirty_reg & ~present_reg) == '0)
        else $error("dirty chunk is not present");

    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        em.en |-> out_free)
        else $error("result written over a waiting result");

    a_accept_starts_align: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DIV))
        else $error("accepted request did not start alignment");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (em.en && em.last) |=> (state_reg == S_IDLE))
        else $error("final result did not end the request");

endmodule
